### hw/rtl/elf_string_hash_bucket_defines.svh
// Assertion macros for the ELF string hash bucket block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ELF_STRING_HASH_BUCKET_DEFINES_SVH
`define ELF_STRING_HASH_BUCKET_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ESHB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ESHB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/eshb_pkg.sv
// Package for the ELF string hash bucket block: widths, sequencer states,
// status structs and the per-byte hash update. No dependencies.
`default_nettype none

package eshb_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned HashW     = 28;
  localparam int unsigned TableW    = 29;
  localparam int unsigned StepShift = 4;
  localparam int unsigned FoldShift = 24;
  localparam int unsigned DivSteps  = HashW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [TableW-1:0] TableReset = TableW'(8);
  localparam logic [31:0]       TopNibble  = 32'hF000_0000;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StEmit
  } state_e;

  // Status of the remainder unit toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

  // One ELF/PJW step: shift in the byte, fold the top nibble back, clear it.
  function automatic logic [HashW-1:0] hash_step(input logic [HashW-1:0] acc,
                                                 input logic [CharW-1:0] c);
    logic [31:0] h;
    logic [31:0] g;
    h = (32'(acc) << StepShift) + 32'(c);
    g = h & TopNibble;
    h = h ^ (g >> FoldShift);
    h = h & ~g;
    return h[HashW-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/eshb_char_if.sv
// Byte channel into the hash block: valid/ready handshake and one key byte.
// Depends on eshb_pkg for the byte width.
`default_nettype none

interface eshb_char_if;
  import eshb_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

### hw/rtl/eshb_bucket_if.sv
// Result channel out of the hash block: valid/ready handshake and the index.
// Depends on eshb_pkg for the index width.
`default_nettype none

interface eshb_bucket_if;
  import eshb_pkg::*;

  logic             valid;
  logic             ready;
  logic [HashW-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink (input valid, input bucket_index, output ready);
endinterface

`default_nettype wire

### hw/rtl/elf_string_hash_bucket.sv
// Top level of the ELF/PJW string hash bucket block.
// Depends on eshb_pkg, eshb_char_if, eshb_bucket_if, eshb_rem_unit and the defines header.
//
//   Channel     Dir  Handshake           Beat contents
//   char_i      in   valid/ready         char_code[7:0], zero ends the key
//   bucket_o    out  valid/ready         bucket_index[27:0]
//   cfg         in   cfg_we_i            cfg_wdata_i[28:0] -> table_size
//
// A nonzero byte is folded into the hash on its beat; the next byte may follow at once.
// A zero byte's beat starts the remainder unit, 28 restoring steps follow, then the
// sequencer sees done and the emit state moves the result into the output register.
// Input ready is low from the zero byte until the result enters the output register;
// a stalled output holds that move, and the block then waits in its emit state.
// Reset clears the hash, sets table_size to 8 and empties the output register.
`default_nettype none

`include "elf_string_hash_bucket_defines.svh"

module elf_string_hash_bucket (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  eshb_char_if.sink                    char_i,
  eshb_bucket_if.source                bucket_o,
  input  logic                         cfg_we_i,
  input  logic [eshb_pkg::TableW-1:0]  cfg_wdata_i
);
  import eshb_pkg::*;

  state_e            state_q, state_d;
  logic [HashW-1:0]  hash_q, hash_d;
  logic [TableW-1:0] table_size_q;
  logic              out_valid_q, out_valid_d;
  logic [HashW-1:0]  out_data_q;

  logic              in_beat;
  logic              key_end;
  logic              rem_start;
  logic              out_load;
  rem_stat_t         rem_stat;
  logic [HashW-1:0]  rem_value;

  assign in_beat = char_i.valid && char_i.ready;
  assign key_end = in_beat && (char_i.char_code == '0);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TableReset;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (key_end) begin
          state_d = StDivide;
        end
      end
      StDivide: begin
        if (rem_stat.done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    char_i.ready = 1'b0;
    rem_start    = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      StIdle: begin
        char_i.ready = 1'b1;
        rem_start    = key_end;
      end
      StDivide: begin
        out_load = 1'b0;
      end
      StEmit: begin
        out_load = !out_valid_q || bucket_o.ready;
      end
      default: begin
        char_i.ready = 1'b0;
      end
    endcase
  end

  // Hash accumulator: one fold per nonzero byte, cleared at key end.
  always_comb begin
    hash_d = hash_q;
    if (key_end) begin
      hash_d = '0;
    end else if (in_beat) begin
      hash_d = hash_step(hash_q, char_i.char_code);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hash_q  <= '0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
    end
  end

  // Remainder unit.
  eshb_rem_unit u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rem_start),
    .dividend_i  (hash_q),
    .divisor_i   (table_size_q),
    .stat_o      (rem_stat),
    .remainder_o (rem_value)
  );

  // Output register, kept apart from the input side.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (bucket_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= rem_value;
    end
  end

  assign bucket_o.valid        = out_valid_q;
  assign bucket_o.bucket_index = out_data_q;

  // Checks on the sequencer and the accumulator.
  `ESHB_ASSERT_NXT(a_key_end_starts_rem, key_end, rem_stat.busy && (hash_q == '0),
                   "key end did not start the remainder unit or clear the hash")
  `ESHB_ASSERT_NOW(a_rise_after_emit, $rose(out_valid_q), $past(state_q == StEmit),
                   "bucket beat appeared without an emit step")
  `ESHB_ASSERT_NOW(a_no_input_while_busy, rem_stat.busy, !char_i.ready && (state_q == StDivide),
                   "input accepted while the remainder unit is busy")
  `ESHB_ASSERT_NOW(a_done_not_busy, rem_stat.done, !rem_stat.busy,
                   "remainder unit reports done and busy together")

endmodule

`default_nettype wire

### hw/rtl/eshb_rem_unit.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on eshb_pkg for widths and the status struct.
`default_nettype none

module eshb_rem_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [eshb_pkg::HashW-1:0]  dividend_i,
  input  logic [eshb_pkg::TableW-1:0] divisor_i,
  output eshb_pkg::rem_stat_t       stat_o,
  output logic [eshb_pkg::HashW-1:0]  remainder_o
);
  import eshb_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [HashW-1:0]   dvd_q, dvd_d;
  logic [TableW-1:0]  div_q, div_d;
  logic [TableW-1:0]  rem_q, rem_d;

  logic [TableW:0]    trial;
  logic [TableW:0]    diff;
  logic               last_step;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial     = {rem_q, dvd_q[HashW-1]};
  assign diff      = trial - {1'b0, div_q};
  assign last_step = (cnt_q == DivCntW'(DivSteps - 1));

  // Step logic: load on start, then one restoring step per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + DivCntW'(1);
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[TableW-1:0];
      end else begin
        rem_d = trial[TableW-1:0];
      end
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  // The remainder stays below the divisor or equals the 28-bit dividend.
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign remainder_o = rem_q[HashW-1:0];

endmodule

`default_nettype wire

### tb/sv/tb_elf_string_hash_bucket.sv
`timescale 1ns / 100ps
// Self-checking testbench for elf_string_hash_bucket: random keys through the byte channel,
// bucket indices compared against an in-bench ELF/PJW predictor. Uses eshb_pkg and both
// channel interfaces.

module tb_elf_string_hash_bucket;
  import eshb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_COUNT  = 11;
  localparam int unsigned PHASE_BYTES  = 140;
  localparam logic [TableW-1:0] BOOT_TABLE_SIZE = TableW'(8);

  // One queued key byte and the idle cycles that precede it.
  typedef struct {
    logic [CharW-1:0] code;
    int unsigned      gap;
  } key_byte_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [TableW-1:0] cfg_wdata_i;

  eshb_char_if   char_bus ();
  eshb_bucket_if bucket_bus ();

  elf_string_hash_bucket dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_bus),
    .bucket_o    (bucket_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state and the store of indices still owed by the block.
  logic [HashW-1:0]  model_hash;
  logic [TableW-1:0] model_table_size;
  logic [HashW-1:0]  expected_buckets[$];
  key_byte_t         pending_bytes[$];

  logic        char_fire;
  logic        bucket_fire;
  logic        tx_idle;
  logic        rx_idle;
  logic        tx_staged;
  logic [CharW-1:0] tx_code;
  int unsigned tx_wait;
  int unsigned rx_stall;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned bytes_taken;
  int unsigned buckets_checked;
  int unsigned sizes_used;

  // One ELF/PJW step with 32-bit wrap: fold the top nibble into bits 7..4, then drop it.
  function automatic logic [HashW-1:0] pjw_absorb(input logic [HashW-1:0] acc,
                                                  input logic [CharW-1:0] c);
    logic [31:0] sum;
    sum = {acc, 4'h0} + {24'h0, c};
    sum[7:4] = sum[7:4] ^ sum[31:28];
    return sum[HashW-1:0];
  endfunction

  // Final reduction; a zero divisor passes the hash through.
  function automatic logic [HashW-1:0] bucket_of(input logic [HashW-1:0] acc,
                                                 input logic [TableW-1:0] ts);
    logic [31:0] rem;
    if (ts == '0) begin
      rem = 32'(acc);
    end else begin
      rem = 32'(acc) % 32'(ts);
    end
    return rem[HashW-1:0];
  endfunction

  // Idle cycles before a beat; a third of the draws are zero even when idling is on.
  function automatic int unsigned draw_gap(input logic enabled);
    if (!enabled || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(1, 14);
  endfunction

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Byte driver: holds a beat until it is taken, then idles as the next byte asks.
  always @(negedge clk_i) begin
    key_byte_t item;
    if (!rst_ni) begin
      char_bus.valid     <= 1'b0;
      char_bus.char_code <= '0;
      tx_staged          <= 1'b0;
      tx_wait            <= 0;
    end else if (!char_bus.valid || char_fire) begin
      if (tx_staged) begin
        if (tx_wait != 0) begin
          tx_wait        <= tx_wait - 1;
          char_bus.valid <= 1'b0;
        end else begin
          char_bus.valid     <= 1'b1;
          char_bus.char_code <= tx_code;
          tx_staged          <= 1'b0;
        end
      end else if (pending_bytes.size() != 0) begin
        item = pending_bytes.pop_front();
        if (item.gap == 0) begin
          char_bus.valid     <= 1'b1;
          char_bus.char_code <= item.code;
        end else begin
          char_bus.valid <= 1'b0;
          tx_staged      <= 1'b1;
          tx_code        <= item.code;
          tx_wait        <= item.gap - 1;
        end
      end else begin
        char_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink: after each beat, stall for a drawn number of cycles while a result waits.
  always @(negedge clk_i) begin
    int unsigned n;
    if (!rst_ni) begin
      bucket_bus.ready <= 1'b0;
      rx_stall         <= 0;
    end else if (bucket_fire) begin
      n = draw_gap(rx_idle);
      rx_stall         <= n;
      bucket_bus.ready <= (n == 0);
    end else if (rx_stall != 0) begin
      if (bucket_bus.valid) begin
        rx_stall <= rx_stall - 1;
      end
      bucket_bus.ready <= (rx_stall == 1) && bucket_bus.valid;
    end else begin
      bucket_bus.ready <= 1'b1;
    end
  end

  // Monitor: tracks configuration, predicts on every accepted byte, checks every index.
  always @(posedge clk_i) begin
    logic [HashW-1:0] want;
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d indices outstanding", cycle_cnt,
               expected_buckets.size());
      $display("FAIL elf_string_hash_bucket");
      $finish;
    end else begin
      char_fire   <= rst_ni && char_bus.valid && char_bus.ready;
      bucket_fire <= rst_ni && bucket_bus.valid && bucket_bus.ready;
      if (!rst_ni) begin
        model_hash       = '0;
        model_table_size = BOOT_TABLE_SIZE;
      end else begin
        if (cfg_we_i) begin
          model_table_size = cfg_wdata_i;
        end
        if (bucket_bus.valid && bucket_bus.ready) begin
          if (expected_buckets.size() == 0) begin
            fail_cnt = fail_cnt + 1;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("Unexpected bucket_index %0d at cycle %0d",
                       bucket_bus.bucket_index, cycle_cnt);
            end
          end else begin
            want = expected_buckets.pop_front();
            buckets_checked = buckets_checked + 1;
            if (bucket_bus.bucket_index !== want) begin
              fail_cnt = fail_cnt + 1;
              if (fail_cnt <= MAX_REPORTS) begin
                $display("bucket_index mismatch at cycle %0d: expected %0d, got %0d",
                         cycle_cnt, want, bucket_bus.bucket_index);
              end
            end
          end
        end
        if (char_bus.valid && char_bus.ready) begin
          bytes_taken = bytes_taken + 1;
          if (char_bus.char_code != '0) begin
            model_hash = pjw_absorb(model_hash, char_bus.char_code);
          end else begin
            expected_buckets.push_back(bucket_of(model_hash, model_table_size));
            model_hash = '0;
          end
        end
      end
    end
  end

  task automatic queue_byte(input logic [CharW-1:0] code);
    key_byte_t item;
    item.code = code;
    item.gap  = draw_gap(tx_idle);
    pending_bytes.push_back(item);
  endtask

  // Random key of mostly short length, closed by its terminator.
  task automatic queue_key(output int unsigned added);
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      len = $urandom_range(0, 8);
    end else if (pick < 19) begin
      len = $urandom_range(9, 24);
    end else begin
      len = $urandom_range(25, 60);
    end
    for (int unsigned i = 0; i < len; i++) begin
      queue_byte(CharW'($urandom_range(1, 255)));
    end
    queue_byte('0);
    added = len + 1;
  endtask

  // Wait until every byte is taken and every index has come, then let the block settle.
  task automatic settle();
    while (pending_bytes.size() != 0 || tx_staged || char_bus.valid ||
           expected_buckets.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_table_size(input logic [TableW-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sizes_used = sizes_used + 1;
  endtask

  initial begin
    logic [TableW-1:0] table_plan[PHASE_COUNT];
    int unsigned added;
    int unsigned phase_bytes;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    bucket_bus.ready   = 1'b0;
    char_fire          = 1'b0;
    bucket_fire        = 1'b0;
    tx_idle            = 1'b0;
    rx_idle            = 1'b0;
    tx_staged          = 1'b0;
    tx_code            = '0;
    tx_wait            = 0;
    rx_stall           = 0;
    cycle_cnt          = 0;
    fail_cnt           = 0;
    bytes_taken        = 0;
    buckets_checked    = 0;
    sizes_used         = 1;

    // Table sizes per phase: the reset value first, then one, zero, the extremes and a mix.
    table_plan = '{BOOT_TABLE_SIZE, TableW'(1), TableW'(0), TableW'(32'h1000_0000),
                   TableW'(32'h1FFF_FFFF), TableW'(3), TableW'(1000), TableW'(0),
                   TableW'(256), TableW'(13), BOOT_TABLE_SIZE};
    table_plan[7] = TableW'($urandom_range(1, 32'h1000_0000));

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed keys under the reset table size, sent back to back.
    queue_byte('0);                        // empty key
    queue_byte(8'h01);
    queue_byte('0);
    queue_byte(8'hFF);
    queue_byte('0);
    queue_byte(8'h80);                     // would be negative as a signed char
    queue_byte('0);
    // Seven 0x0F bytes fill the accumulator; the 0xFF then carries out of 32 bits.
    repeat (7) queue_byte(8'h0F);
    queue_byte(8'hFF);
    queue_byte('0);
    // A long run of 0xFF forces the top nibble to fold back.
    repeat (8) queue_byte(8'hFF);
    queue_byte('0);

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      if (p != 0) begin
        write_table_size(table_plan[p]);
      end
      tx_idle     = (p % 3 != 1);
      rx_idle     = (p % 3 != 2);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        queue_key(added);
        phase_bytes = phase_bytes + added;
      end
    end

    settle();
    $display("Checked %0d bucket indices from %0d key bytes under %0d table sizes.",
             buckets_checked, bytes_taken, sizes_used);
    $display("Sizes spanned zero, one, 2^28 and the all-ones divisor, with idle and stall gaps.");
    if (fail_cnt == 0 && expected_buckets.size() == 0) begin
      $display("PASS elf_string_hash_bucket");
    end else begin
      $display("%0d failures, %0d indices never arrived", fail_cnt, expected_buckets.size());
      $display("FAIL elf_string_hash_bucket");
    end
    $finish;
  end

endmodule

### elf_string_hash_bucket.f
+incdir+hw/rtl
hw/rtl/eshb_pkg.sv
hw/rtl/eshb_char_if.sv
hw/rtl/eshb_bucket_if.sv
hw/rtl/eshb_rem_unit.sv
hw/rtl/elf_string_hash_bucket.sv
tb/sv/tb_elf_string_hash_bucket.sv
